// ===== rtl/core/two_channel_incremental_pid_unit_defines.svh =====
// assertion macros for the two-channel incremental pid unit
// expects clk and arst_n in the scope of use
`ifndef TWO_CHANNEL_INCREMENTAL_PID_UNIT_DEFINES_SVH
`define TWO_CHANNEL_INCREMENTAL_PID_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCPID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TCPID_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCPID_ASSERT(lbl, prop, msg)
`define TCPID_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/tcpid_pkg.sv =====
// types, register codes and reset values for the incremental pid unit
// no dependencies
`default_nettype none
package tcpid_pkg;
	localparam int NUM_CH     = 2;
	localparam int GAIN_W     = 24;
	localparam int LIM_W      = 16;
	localparam int DB_W       = 15;
	localparam int ERR_W      = 17;
	localparam int ANGLE_W    = 16;
	localparam int ACC_W      = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_AIL  = 4'd0,
		REG_KI_AIL  = 4'd1,
		REG_KD_AIL  = 4'd2,
		REG_KP_LIFT = 4'd3,
		REG_KI_LIFT = 4'd4,
		REG_KD_LIFT = 4'd5,
		REG_DEADBAND = 4'd6,
		REG_LIMITS  = 4'd7
	} reg_idx_t;

	localparam logic [GAIN_W-1:0] KP_AIL_RST  = 24'd727450;
	localparam logic [GAIN_W-1:0] KI_AIL_RST  = 24'd29098;
	localparam logic [GAIN_W-1:0] KD_AIL_RST  = 24'd14549;
	localparam logic [GAIN_W-1:0] KP_LIFT_RST = 24'd1454899;
	localparam logic [GAIN_W-1:0] KI_LIFT_RST = 24'd11085;
	localparam logic [GAIN_W-1:0] KD_LIFT_RST = 24'd1819;
	localparam logic [DB_W-1:0]   DB_RST      = 15'd0;
	localparam logic [CFG_DATA_W-1:0] LIMITS_RST = 64'hFFFF_0000_FFFF_0000;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [LIM_W-1:0]  lim_lo;
		logic [LIM_W-1:0]  lim_hi;
	} chan_cfg_t;

	typedef struct packed {
		chan_cfg_t [NUM_CH-1:0] chan;
		logic [DB_W-1:0]        dead_band;
	} cfg_t;
endpackage
`default_nettype wire

// ===== rtl/core/two_channel_incremental_pid_unit.sv =====
// two-channel incremental pid unit, top level
// a sample beat is held in stage 1 registers, then its result in the result register
// throughput: one beat per cycle when not stalled; each pid step runs in one registered pass
// reset: gains, deadband and limits to defaults, histories, accumulators and tick flag to zero
// depends on tcpid_pkg, tcpid_regs, tcpid_calc and the assertion macro header
`default_nettype none
`include "two_channel_incremental_pid_unit_defines.svh"
module two_channel_incremental_pid_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tcpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcpid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             action,
	input  wire logic                             channel,
	input  wire logic signed [tcpid_pkg::ANGLE_W-1:0] feedback,
	input  wire logic signed [tcpid_pkg::ANGLE_W-1:0] setpoint,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic [tcpid_pkg::ACC_W-1:0]           drive_value,
	output logic                                  updated
);
	import tcpid_pkg::*;

	cfg_t cfg;

	assign cfg_ready = 1'b1;

	tcpid_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// error and deadband on the incoming beat
	logic signed [ERR_W-1:0] err_in, err_db;
	logic [ERR_W-1:0]        err_mag;

	assign err_in  = {setpoint[ANGLE_W-1], setpoint} - {feedback[ANGLE_W-1], feedback};
	assign err_mag = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
	assign err_db  = (err_mag < {{(ERR_W-DB_W){1'b0}}, cfg.dead_band}) ? '0 : err_in;

	logic                    valid_s1, action_s1, channel_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic                    s1_go, res_free;

	logic                    pending_q;
	logic signed [ERR_W-1:0] last_err_q  [NUM_CH];
	logic signed [ERR_W-1:0] older_err_q [NUM_CH];
	logic [ACC_W-1:0]        acc_q       [NUM_CH];

	logic                    result_valid_q, updated_q;
	logic [ACC_W-1:0]        drive_q, acc_next;

	// ticks never need the result register
	assign res_free   = !result_valid_q || !result_stall;
	assign s1_go      = valid_s1 && (!action_s1 || res_free);
	assign item_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1  <= action;
			channel_s1 <= channel;
			err_s1     <= err_db;
		end
	end

	tcpid_calc u_calc (
		.ccfg     (cfg.chan[channel_s1]),
		.err      (err_s1),
		.err1     (last_err_q[channel_s1]),
		.err2     (older_err_q[channel_s1]),
		.acc      (acc_q[channel_s1]),
		.acc_next (acc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				last_err_q[i]  <= '0;
				older_err_q[i] <= '0;
				acc_q[i]       <= '0;
			end
		end else if (s1_go) begin
			if (!action_s1) begin
				pending_q <= 1'b1;
			end else if (pending_q) begin
				pending_q               <= 1'b0;
				older_err_q[channel_s1] <= last_err_q[channel_s1];
				last_err_q[channel_s1]  <= err_s1;
				acc_q[channel_s1]       <= acc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && action_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && action_s1) begin
			drive_q   <= pending_q ? acc_next : acc_q[channel_s1];
			updated_q <= pending_q;
		end
	end

	assign result_valid = result_valid_q;
	assign drive_value  = drive_q;
	assign updated      = updated_q;

	`TCPID_ASSERT(a_accept_fills_s1, (item_valid && !item_stall) |=> valid_s1, "accepted beat lost before stage 1")
	`TCPID_ASSERT(a_sample_clears_flag, (s1_go && action_s1) |=> !pending_q, "tick flag still armed after a sample")
	`TCPID_ASSERT(a_result_matches_acc, (s1_go && action_s1) |=> (result_valid && drive_value == acc_q[$past(channel_s1)]), "result differs from stored accumulator")
	`TCPID_ASSERT_RST(a_reset_empty, (!arst_n) |-> (!result_valid && !valid_s1), "pipeline not empty in reset")
endmodule
`default_nettype wire

// ===== rtl/core/tcpid_regs.sv =====
// configuration register file: gains, deadband and output limits
// depends on tcpid_pkg
`default_nettype none
module tcpid_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [tcpid_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [tcpid_pkg::CFG_DATA_W-1:0] wr_data,
	output tcpid_pkg::cfg_t                       cfg
);
	import tcpid_pkg::*;

	logic [GAIN_W-1:0]     kp_ail_q, ki_ail_q, kd_ail_q;
	logic [GAIN_W-1:0]     kp_lift_q, ki_lift_q, kd_lift_q;
	logic [DB_W-1:0]       db_q;
	logic [CFG_DATA_W-1:0] limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_ail_q  <= KP_AIL_RST;
			ki_ail_q  <= KI_AIL_RST;
			kd_ail_q  <= KD_AIL_RST;
			kp_lift_q <= KP_LIFT_RST;
			ki_lift_q <= KI_LIFT_RST;
			kd_lift_q <= KD_LIFT_RST;
			db_q      <= DB_RST;
			limits_q  <= LIMITS_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_KP_AIL:   kp_ail_q  <= wr_data[GAIN_W-1:0];
				REG_KI_AIL:   ki_ail_q  <= wr_data[GAIN_W-1:0];
				REG_KD_AIL:   kd_ail_q  <= wr_data[GAIN_W-1:0];
				REG_KP_LIFT:  kp_lift_q <= wr_data[GAIN_W-1:0];
				REG_KI_LIFT:  ki_lift_q <= wr_data[GAIN_W-1:0];
				REG_KD_LIFT:  kd_lift_q <= wr_data[GAIN_W-1:0];
				REG_DEADBAND: db_q      <= wr_data[DB_W-1:0];
				REG_LIMITS:   limits_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.chan[0].kp     = kp_ail_q;
	assign cfg.chan[0].ki     = ki_ail_q;
	assign cfg.chan[0].kd     = kd_ail_q;
	assign cfg.chan[0].lim_lo = limits_q[15:0];
	assign cfg.chan[0].lim_hi = limits_q[31:16];
	assign cfg.chan[1].kp     = kp_lift_q;
	assign cfg.chan[1].ki     = ki_lift_q;
	assign cfg.chan[1].kd     = kd_lift_q;
	assign cfg.chan[1].lim_lo = limits_q[47:32];
	assign cfg.chan[1].lim_hi = limits_q[63:48];
	assign cfg.dead_band      = db_q;
endmodule
`default_nettype wire

// ===== rtl/core/tcpid_calc.sv =====
// one velocity-form pid step: three gain products, rounding, accumulate, clamp
// depends on tcpid_pkg
`default_nettype none
module tcpid_calc (
	input  wire tcpid_pkg::chan_cfg_t              ccfg,
	input  wire logic signed [tcpid_pkg::ERR_W-1:0] err,
	input  wire logic signed [tcpid_pkg::ERR_W-1:0] err1,
	input  wire logic signed [tcpid_pkg::ERR_W-1:0] err2,
	input  wire logic [tcpid_pkg::ACC_W-1:0]        acc,
	output logic [tcpid_pkg::ACC_W-1:0]             acc_next
);
	import tcpid_pkg::*;

	localparam int DP_W  = ERR_W + 1;
	localparam int DD_W  = ERR_W + 2;
	localparam int PP_W  = GAIN_W + 1 + DP_W;
	localparam int PI_W  = GAIN_W + 1 + ERR_W;
	localparam int PD_W  = GAIN_W + 1 + DD_W;
	localparam int SUM_W = PD_W + 2;
	localparam int INC_W = SUM_W - 8;
	localparam int VAL_W = INC_W + 2;

	logic signed [DP_W-1:0]  d_p;
	logic signed [DD_W-1:0]  d_d;
	logic signed [PP_W-1:0]  prod_p;
	logic signed [PI_W-1:0]  prod_i;
	logic signed [PD_W-1:0]  prod_d;
	logic signed [SUM_W-1:0] sum, rnd;
	logic signed [INC_W-1:0] inc;
	logic signed [VAL_W-1:0] val, lo, hi;

	assign d_p = {err[ERR_W-1], err} - {err1[ERR_W-1], err1};
	assign d_d = {{2{err[ERR_W-1]}}, err} - {err1[ERR_W-1], err1, 1'b0}
		+ {{2{err2[ERR_W-1]}}, err2};

	assign prod_p = $signed({1'b0, ccfg.kp}) * d_p;
	assign prod_i = $signed({1'b0, ccfg.ki}) * err;
	assign prod_d = $signed({1'b0, ccfg.kd}) * d_d;

	assign sum = {{(SUM_W-PP_W){prod_p[PP_W-1]}}, prod_p}
		+ {{(SUM_W-PI_W){prod_i[PI_W-1]}}, prod_i}
		+ {{(SUM_W-PD_W){prod_d[PD_W-1]}}, prod_d};
	// round half up from q.24 to q16.16, arithmetic shift floors
	assign rnd = sum + SUM_W'(128);
	assign inc = rnd[SUM_W-1:8];

	assign val = $signed({{(VAL_W-ACC_W){1'b0}}, acc}) + {{2{inc[INC_W-1]}}, inc};
	assign lo  = $signed({{(VAL_W-ACC_W){1'b0}}, ccfg.lim_lo, 16'h0000});
	assign hi  = $signed({{(VAL_W-ACC_W){1'b0}}, ccfg.lim_hi, 16'h0000});

	// minimum test wins when the limits cross
	always_comb begin
		if (val < lo) begin
			acc_next = lo[ACC_W-1:0];
		end else if (val > hi) begin
			acc_next = hi[ACC_W-1:0];
		end else begin
			acc_next = val[ACC_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== bench/incremental_pid_checker.sv =====
// checker for the two-channel incremental pid unit: tracks register writes,
// predicts each sample beat's drive value and compares the result beats in order
// depends on tcpid_pkg
module incremental_pid_checker
	import tcpid_pkg::*;
#(
	parameter logic ACT_TICK = 1'b0,
	parameter logic CH_AIL   = 1'b0,
	parameter logic CH_LIFT  = 1'b1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  item_valid,
	input  wire logic                  item_stall,
	input  wire logic                  action,
	input  wire logic                  channel,
	input  wire logic [ANGLE_W-1:0]    feedback,
	input  wire logic [ANGLE_W-1:0]    setpoint,
	input  wire logic                  result_valid,
	input  wire logic                  result_stall,
	input  wire logic [ACC_W-1:0]      drive_value,
	input  wire logic                  updated,
	output int                         mismatches,
	output int                         outstanding
);
	typedef struct {
		logic [ACC_W-1:0] drive;
		logic             updated;
		logic             ch;
	} drive_beat_t;

	logic [GAIN_W-1:0]        kp_gain [NUM_CH];
	logic [GAIN_W-1:0]        ki_gain [NUM_CH];
	logic [GAIN_W-1:0]        kd_gain [NUM_CH];
	logic [LIM_W-1:0]         lim_lo [NUM_CH];
	logic [LIM_W-1:0]         lim_hi [NUM_CH];
	logic [DB_W-1:0]          band;
	logic                     tick_armed;
	logic signed [ERR_W-1:0]  err_last [NUM_CH];
	logic signed [ERR_W-1:0]  err_older [NUM_CH];
	logic [ACC_W-1:0]         drive_acc [NUM_CH];
	drive_beat_t              expected_drives [$];
	int                       mismatch_count = 0;
	int                       waiting = 0;

	assign mismatches  = mismatch_count;
	assign outstanding = waiting;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_KP_AIL:   kp_gain[CH_AIL]  = data[GAIN_W-1:0];
			REG_KI_AIL:   ki_gain[CH_AIL]  = data[GAIN_W-1:0];
			REG_KD_AIL:   kd_gain[CH_AIL]  = data[GAIN_W-1:0];
			REG_KP_LIFT:  kp_gain[CH_LIFT] = data[GAIN_W-1:0];
			REG_KI_LIFT:  ki_gain[CH_LIFT] = data[GAIN_W-1:0];
			REG_KD_LIFT:  kd_gain[CH_LIFT] = data[GAIN_W-1:0];
			REG_DEADBAND: band = data[DB_W-1:0];
			REG_LIMITS: begin
				lim_lo[CH_AIL]  = data[0 +: LIM_W];
				lim_hi[CH_AIL]  = data[LIM_W +: LIM_W];
				lim_lo[CH_LIFT] = data[2*LIM_W +: LIM_W];
				lim_hi[CH_LIFT] = data[3*LIM_W +: LIM_W];
			end
			default: ;
		endcase
	endtask

	task automatic clear_state();
		set_register(REG_KP_AIL, CFG_DATA_W'(KP_AIL_RST));
		set_register(REG_KI_AIL, CFG_DATA_W'(KI_AIL_RST));
		set_register(REG_KD_AIL, CFG_DATA_W'(KD_AIL_RST));
		set_register(REG_KP_LIFT, CFG_DATA_W'(KP_LIFT_RST));
		set_register(REG_KI_LIFT, CFG_DATA_W'(KI_LIFT_RST));
		set_register(REG_KD_LIFT, CFG_DATA_W'(KD_LIFT_RST));
		set_register(REG_DEADBAND, CFG_DATA_W'(DB_RST));
		set_register(REG_LIMITS, LIMITS_RST);
		tick_armed = 1'b0;
		for (int c = 0; c < NUM_CH; c++) begin
			err_last[c]  = '0;
			err_older[c] = '0;
			drive_acc[c] = '0;
		end
		expected_drives.delete();
	endtask

	// one velocity-form step: the increment is rounded half up from q.24 to q16.16
	task automatic run_pid_step(input logic act, input logic ch,
			input logic signed [ANGLE_W-1:0] fb, input logic signed [ANGLE_W-1:0] sp);
		longint err, e1, e2, mag, total, next_acc, lo, hi;
		drive_beat_t beat;
		beat.ch = ch;
		if (act == ACT_TICK) begin
			tick_armed = 1'b1;
		end else if (!tick_armed) begin
			beat.drive   = drive_acc[ch];
			beat.updated = 1'b0;
			expected_drives.push_back(beat);
		end else begin
			err = longint'(sp) - longint'(fb);
			mag = (err < 0) ? -err : err;
			if (mag < longint'(band))
				err = 0;
			e1 = longint'(err_last[ch]);
			e2 = longint'(err_older[ch]);
			total = longint'(kp_gain[ch]) * (err - e1)
				+ longint'(ki_gain[ch]) * err
				+ longint'(kd_gain[ch]) * (err - 2 * e1 + e2);
			next_acc = longint'(drive_acc[ch]) + ((total + 128) >>> 8);
			lo = longint'(lim_lo[ch]) * 65536;
			hi = longint'(lim_hi[ch]) * 65536;
			// minimum test first, so it wins when the limits cross
			if (next_acc < lo)
				next_acc = lo;
			else if (next_acc > hi)
				next_acc = hi;
			err_older[ch] = err_last[ch];
			err_last[ch]  = ERR_W'(err);
			drive_acc[ch] = ACC_W'(next_acc);
			tick_armed    = 1'b0;
			beat.drive    = drive_acc[ch];
			beat.updated  = 1'b1;
			expected_drives.push_back(beat);
		end
	endtask

	// result beats are matched before new samples are taken in, since a sample
	// cannot come out at the edge that accepts it
	always @(posedge clk or negedge arst_n) begin : watch
		drive_beat_t oldest;
		if (!arst_n) begin
			clear_state();
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_drives.size() == 0) begin
					report_mismatch("result beat with no sample waiting");
				end else begin
					oldest = expected_drives.pop_front();
					if (drive_value !== oldest.drive)
						report_mismatch($sformatf("ch %0d drive_value %08h, expected %08h",
							oldest.ch, drive_value, oldest.drive));
					if (updated !== oldest.updated)
						report_mismatch($sformatf("ch %0d updated %b, expected %b",
							oldest.ch, updated, oldest.updated));
				end
			end
			if (cfg_valid && cfg_ready)
				set_register(cfg_index, cfg_data);
			if (item_valid && !item_stall)
				run_pid_step(action, channel, feedback, setpoint);
		end
		waiting = expected_drives.size();
	end
endmodule

// ===== bench/two_channel_incremental_pid_unit_tb.sv =====
// testbench top for the two-channel incremental pid unit: clock, reset, register
// phases, directed and random tick/sample beats, random stalls and the verdict
// depends on tcpid_pkg, incremental_pid_checker and the unit itself
module two_channel_incremental_pid_unit_tb;
	import tcpid_pkg::*;

	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_SAMPLE  = 1'b1;
	localparam logic CH_AIL      = 1'b0;
	localparam logic CH_LIFT     = 1'b1;
	localparam int   PHASES      = 6;
	localparam int   PHASE_ITEMS = 180;
	localparam int   MAX_GAP     = 6;
	localparam int   SETTLE      = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_stall;
	logic                  action;
	logic                  channel;
	logic [ANGLE_W-1:0]    feedback;
	logic [ANGLE_W-1:0]    setpoint;
	logic                  result_valid;
	logic                  result_stall;
	logic [ACC_W-1:0]      drive_value;
	logic                  updated;
	int                    mismatches;
	int                    outstanding;
	bit                    no_gaps;
	logic [DB_W-1:0]       band_now;

	two_channel_incremental_pid_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.action(action), .channel(channel),
		.feedback(feedback), .setpoint(setpoint),
		.result_valid(result_valid), .result_stall(result_stall),
		.drive_value(drive_value), .updated(updated)
	);

	incremental_pid_checker #(
		.ACT_TICK(ACT_TICK), .CH_AIL(CH_AIL), .CH_LIFT(CH_LIFT)
	) i_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.action(action), .channel(channel),
		.feedback(feedback), .setpoint(setpoint),
		.result_valid(result_valid), .result_stall(result_stall),
		.drive_value(drive_value), .updated(updated),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// a beat stays on the bus until the edge that takes it; valid stays high
	// into the next beat when no gap is drawn
	task automatic send_item(input logic act, input logic ch,
			input logic [ANGLE_W-1:0] fb, input logic [ANGLE_W-1:0] sp);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action     <= act;
		channel    <= ch;
		feedback   <= fb;
		setpoint   <= sp;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic tick();
		send_item(ACT_TICK, 1'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom));
	endtask

	// errors are full range, small, or straddling the deadband edge
	task automatic random_sample();
		logic [ANGLE_W-1:0] sp;
		logic [ANGLE_W-1:0] fb;
		int delta;
		sp = ANGLE_W'($urandom);
		case ($urandom_range(0, 2))
			0: fb = ANGLE_W'($urandom);
			1: fb = sp + ANGLE_W'($urandom_range(0, 1023) - 512);
			default: begin
				delta = int'(band_now) + $urandom_range(0, 4) - 2;
				if ($urandom_range(0, 1) != 0)
					delta = -delta;
				fb = sp + ANGLE_W'(delta);
			end
		endcase
		send_item(ACT_SAMPLE, 1'($urandom), fb, sp);
	endtask

	// caller lowers cfg_valid after the last write of a batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain(input int kind);
		if (kind == 0)
			return '0;
		if (kind == 1)
			return '1;
		case ($urandom_range(0, 4))
			0: return GAIN_W'($urandom_range(0, 1 << 18));
			1: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(0, 1 << 12));
		endcase
	endfunction

	// kind 0: all gains and limits zero, widest deadband; kind 1: gains and
	// limits at their top, no deadband; otherwise random
	task automatic load_settings(input int kind);
		logic [CFG_DATA_W-1:0] data;
		logic [LIM_W-1:0] lo0, hi0, lo1, hi1;
		if (kind > 1 && $urandom_range(0, 1) != 0)
			write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_LIMITS) + 1)),
				{$urandom, $urandom});
		for (int i = 0; i <= int'(REG_LIMITS); i++) begin
			data = {$urandom, $urandom};
			case (reg_idx_t'(i))
				REG_DEADBAND: begin
					if (kind == 0)
						data[DB_W-1:0] = '1;
					else if (kind == 1)
						data[DB_W-1:0] = '0;
					else if ($urandom_range(0, 2) != 0)
						data[DB_W-1:0] = DB_W'($urandom_range(0, 600));
					band_now = data[DB_W-1:0];
				end
				REG_LIMITS: begin
					if (kind == 0) begin
						data = '0;
					end else if (kind == 1) begin
						data = '1;
					end else if ($urandom_range(0, 3) != 0) begin
						lo0 = LIM_W'($urandom_range(0, 30000));
						hi0 = lo0 + LIM_W'($urandom_range(0, 35000));
						lo1 = LIM_W'($urandom_range(0, 30000));
						hi1 = lo1 + LIM_W'($urandom_range(0, 35000));
						data = {hi1, lo1, hi0, lo0};
					end
				end
				default: data[GAIN_W-1:0] = pick_gain(kind);
			endcase
			write_reg(CFG_IDX_W'(i), data);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int result_wait;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			result_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
			if (result_wait > 0) begin
				result_stall <= 1'b1;
				repeat (result_wait) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		int pick;
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		item_valid <= 1'b0;
		action     <= ACT_TICK;
		channel    <= CH_AIL;
		feedback   <= '0;
		setpoint   <= '0;
		no_gaps    = 1'b0;
		band_now   = DB_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: held values, repeated ticks, full-scale errors
		send_item(ACT_SAMPLE, CH_AIL, 16'h0000, 16'h0000);
		send_item(ACT_SAMPLE, CH_LIFT, 16'h1234, 16'hEDCB);
		tick();
		tick();
		send_item(ACT_SAMPLE, CH_AIL, 16'h8000, 16'h7FFF);
		send_item(ACT_SAMPLE, CH_AIL, 16'h0000, 16'h0100);
		tick();
		send_item(ACT_SAMPLE, CH_LIFT, 16'h7FFF, 16'h8000);
		tick();
		send_item(ACT_SAMPLE, CH_AIL, 16'h7FFF, 16'h7FFF);
		tick();
		send_item(ACT_SAMPLE, CH_AIL, 16'h0100, 16'h0000);
		tick();
		send_item(ACT_SAMPLE, CH_LIFT, 16'hFFFF, 16'h0001);

		// deadband of 0x0100 and crossed aileron limits
		drain();
		write_reg(REG_KP_AIL, 64'hFFFFFF);
		write_reg(REG_KI_AIL, 64'h0);
		write_reg(REG_KD_AIL, 64'hFFFFFF);
		write_reg(REG_KP_LIFT, 64'h0);
		write_reg(REG_KI_LIFT, 64'hFFFFFF);
		write_reg(REG_KD_LIFT, 64'h010000);
		write_reg(REG_DEADBAND, 64'h0100);
		write_reg(REG_LIMITS, {16'hFFFF, 16'h0000, 16'h0040, 16'h0080});
		cfg_valid <= 1'b0;
		band_now = 15'h0100;
		tick();
		send_item(ACT_SAMPLE, CH_AIL, 16'h0000, 16'h0100);
		tick();
		send_item(ACT_SAMPLE, CH_AIL, 16'h0000, 16'h00FF);
		tick();
		send_item(ACT_SAMPLE, CH_AIL, 16'h00FF, 16'h0000);
		tick();
		send_item(ACT_SAMPLE, CH_LIFT, 16'h0100, 16'h0000);
		tick();
		send_item(ACT_SAMPLE, CH_LIFT, 16'h8000, 16'h7FFF);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			load_settings(p);
			for (int n = 0; n < PHASE_ITEMS; ) begin
				if ($urandom_range(0, 39) == 0)
					no_gaps = ($urandom_range(0, 2) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// well-formed period: tick then sample, now and then a double tick
					repeat ($urandom_range(1, 2)) begin
						tick();
						n++;
					end
					random_sample();
					n++;
				end else if (pick < 85) begin
					random_sample();
					n++;
				end else begin
					tick();
					n++;
				end
			end
		end

		item_valid <= 1'b0;
		no_gaps = 1'b0;
		for (int k = 0; k < 2000; k++) begin
			@(posedge clk);
			if (outstanding == 0)
				break;
		end
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
